// ===== rtl/fa_clk_pkg.sv =====
package fa_clk_pkg;

  localparam int FRAMES     = 1024;
  localparam int IDX_W      = $clog2(FRAMES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MAX_RUN    = 64;
  localparam int RUN_W      = 7;
  localparam int OWNER_BITS = 16;
  localparam int META_W     = 2 + RUN_W + 1;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_TOUCH   = 2'd2;
  localparam logic [1:0] OP_ILLEGAL = 2'd3;

  localparam logic [1:0] KIND_FREE   = 2'd0;
  localparam logic [1:0] KERNELPAGE  = 2'd1;
  localparam logic [1:0] USERPAGE    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [1:0] CFG_TOTAL  = 2'd0;
  localparam logic [1:0] CFG_SWAP   = 2'd1;
  localparam logic [1:0] CFG_CSTART = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [6:0]            page_count;
    logic [1:0]            page_kind;
    logic [OWNER_BITS-1:0] owner_tag;
    logic [9:0]            frame_index;
  } fa_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [9:0]            frame_out;
    logic                  evicted;
    logic [OWNER_BITS-1:0] victim_owner;
    logic [10:0]           used_pages;
  } fa_out_t;

endpackage

// ===== rtl/frame_allocator_clock_evict_top.sv =====
// Frame allocator with first-fit runs and second-chance clock eviction.
// Input channel (in_valid / in_stall / in_data) takes one request word:
//   allocate a run, free a run at its start frame, or touch a frame.
// Output channel (out_valid / out_stall / out_data) returns one result word
//   per request, with status and the used-frame count after the request.
// Config port (cfg_we / cfg_index / cfg_wdata) writes total_frames,
//   swap_enable and clock_start; write only while the block is idle.
// Per-frame kind, run length and referenced bit live in one 1024-entry
//   synchronous RAM, owner tags in a second one. Each frame access is a
//   registered read followed, where the entry changes, by a modify/write.
// A bad request goes straight to its result; touch reads a frame, updates it
//   if used; free reads the given frame and, if it starts a run, clears each
//   frame of the run; allocate scans frames for a free run, then marks
//   each frame of it; with eviction the clock hand steps on, up to twice
//   around the managed frames, until it finds an unreferenced user frame.
// Only one request is in flight; in_stall is high until its result is
//   loaded into the output register. A stalled output holds its word and a
//   new request may be taken meanwhile; the following result waits.
// After reset a clearing pass writes all 1024 map entries, with in_stall
//   high; config writes are taken during that pass.
module frame_allocator_clock_evict_top
  import fa_clk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fa_in_t             in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fa_out_t            out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CNT_W-1:0]   cfg_wdata
);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_EV  = 4'd3;
  localparam logic [3:0] S_FAIL     = 4'd4;
  localparam logic [3:0] S_MARK_RD  = 4'd5;
  localparam logic [3:0] S_MARK_EV  = 4'd6;
  localparam logic [3:0] S_EVI_RD   = 4'd7;
  localparam logic [3:0] S_EVI_EV   = 4'd8;
  localparam logic [3:0] S_FREE_CHK = 4'd9;
  localparam logic [3:0] S_FREE_RD  = 4'd10;
  localparam logic [3:0] S_FREE_EV  = 4'd11;
  localparam logic [3:0] S_TOUCH_RD = 4'd12;
  localparam logic [3:0] S_TOUCH_EV = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);
  localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);

  // config
  logic [CNT_W-1:0] total_r;
  logic             swap_r;
  logic [IDX_W-1:0] cstart_r;

  // control
  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [CNT_W:0]   steps_r, steps_nxt;
  logic [IDX_W-1:0] hand_r, hand_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  fa_in_t           req_r, req_nxt;
  fa_out_t          res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  fa_out_t          out_data_r, out_data_nxt;

  // map memories
  logic [META_W-1:0]     meta_mem [FRAMES];
  logic [OWNER_BITS-1:0] owner_mem [FRAMES];
  logic [META_W-1:0]     meta_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic                  meta_we, owner_we;
  logic [META_W-1:0]     meta_wd;

  logic [1:0]       kind_q;
  logic [RUN_W-1:0] runl_q;
  logic             ref_q;
  logic [CNT_W-1:0] n_mng;
  logic [RUN_W-1:0] run_inc;
  logic [CNT_W-1:0] free_end;

  assign kind_q = meta_q[META_W-1 -: 2];
  assign runl_q = meta_q[RUN_W:1];
  assign ref_q  = meta_q[0];
  assign n_mng  = (total_r > FRAMES_C) ? FRAMES_C : total_r;
  assign run_inc = (kind_q == KIND_FREE) ? run_r + RUN_W'(1) : '0;
  assign free_end = CNT_W'(idx_r) + CNT_W'(runl_q);

  function automatic logic [IDX_W-1:0] hand_next(input logic [IDX_W-1:0] h,
                                                  input logic [CNT_W-1:0] n,
                                                  input logic [IDX_W-1:0] cs);
    logic [CNT_W-1:0] hp;
    hp = CNT_W'(h) + CNT_W'(1);
    if (hp >= n) begin
      hand_next = (CNT_W'(cs) < n) ? cs : '0;
    end else begin
      hand_next = hp[IDX_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    meta_q  <= meta_mem[idx_r];
    owner_q <= owner_mem[idx_r];
    if (meta_we) begin
      meta_mem[idx_r] <= meta_wd;
    end
    if (owner_we) begin
      owner_mem[idx_r] <= req_r.owner_tag;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    run_nxt       = run_r;
    steps_nxt     = steps_r;
    hand_nxt      = hand_r;
    used_nxt      = used_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    meta_we       = 1'b0;
    owner_we      = 1'b0;
    meta_wd       = meta_q;

    unique case (state_r)
      S_CLR: begin
        meta_we = 1'b1;
        meta_wd = '0;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          res_nxt.status = ST_BAD;
          state_nxt = S_DONE;
          case (in_data.opcode)
            OP_ALLOC: begin
              if (in_data.page_count != '0 && in_data.page_count <= 7'(MAX_RUN) &&
                  in_data.page_kind != KIND_FREE) begin
                idx_nxt   = '0;
                run_nxt   = '0;
                state_nxt = (n_mng == '0) ? S_FAIL : S_SCAN_RD;
              end
            end
            OP_FREE: begin
              // free goes through a range check of the frame index first
              if (CNT_W'(in_data.frame_index) < n_mng) begin
                idx_nxt   = in_data.frame_index;
                state_nxt = S_FREE_RD;
                last_nxt  = '0;
              end
            end
            OP_TOUCH: begin
              if (CNT_W'(in_data.frame_index) < n_mng) begin
                idx_nxt   = in_data.frame_index;
                state_nxt = S_TOUCH_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (run_inc == req_r.page_count) begin
          idx_nxt  = idx_r - IDX_W'(req_r.page_count) + IDX_W'(1);
          last_nxt = idx_r;
          used_nxt = used_r + CNT_W'(req_r.page_count);
          res_nxt.status    = ST_OK;
          res_nxt.frame_out = idx_r - IDX_W'(req_r.page_count) + IDX_W'(1);
          state_nxt = S_MARK_RD;
        end else if (CNT_W'(idx_r) + CNT_W'(1) == n_mng) begin
          state_nxt = S_FAIL;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          run_nxt   = run_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_FAIL: begin
        if (swap_r && req_r.page_count == 7'd1 && n_mng != '0) begin
          idx_nxt   = hand_next(hand_r, n_mng, cstart_r);
          steps_nxt = '0;
          state_nxt = S_EVI_RD;
        end else begin
          res_nxt.status = ST_NOMEM;
          state_nxt      = S_DONE;
        end
      end
      S_MARK_RD: state_nxt = S_MARK_EV;
      S_MARK_EV: begin
        meta_we  = 1'b1;
        owner_we = 1'b1;
        meta_wd  = {req_r.page_kind,
                    (idx_r == res_r.frame_out) ? req_r.page_count : RUN_W'(0),
                    ref_q};
        if (idx_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_MARK_RD;
        end
      end
      S_EVI_RD: state_nxt = S_EVI_EV;
      S_EVI_EV: begin
        meta_we = 1'b1;
        if (kind_q == USERPAGE && !ref_q) begin
          owner_we = 1'b1;
          meta_wd  = {req_r.page_kind, runl_q, 1'b1};
          hand_nxt = idx_r;
          res_nxt.status       = ST_OK;
          res_nxt.frame_out    = idx_r;
          res_nxt.evicted      = 1'b1;
          res_nxt.victim_owner = owner_q;
          state_nxt = S_DONE;
        end else begin
          meta_wd = {kind_q, runl_q, 1'b0};
          if (steps_r + (CNT_W+1)'(1) < {n_mng, 1'b0}) begin
            idx_nxt   = hand_next(idx_r, n_mng, cstart_r);
            steps_nxt = steps_r + (CNT_W+1)'(1);
            state_nxt = S_EVI_RD;
          end else begin
            hand_nxt       = idx_r;
            res_nxt.status = ST_NOMEM;
            state_nxt      = S_DONE;
          end
        end
      end
      S_FREE_CHK: begin
        if (runl_q == '0) begin
          state_nxt = S_DONE;
        end else begin
          last_nxt  = (free_end >= FRAMES_C) ? LAST_IDX : IDX_W'(free_end - CNT_W'(1));
          res_nxt.status = ST_OK;
          state_nxt = S_FREE_EV;
        end
      end
      S_FREE_RD: begin
        state_nxt = (res_r.status == ST_OK) ? S_FREE_EV : S_FREE_CHK;
      end
      S_FREE_EV: begin
        meta_we = 1'b1;
        meta_wd = {KIND_FREE, RUN_W'(0), ref_q};
        if (kind_q != KIND_FREE && used_r != '0) begin
          used_nxt = used_r - CNT_W'(1);
        end
        if (idx_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_FREE_RD;
        end
      end
      S_TOUCH_RD: state_nxt = S_TOUCH_EV;
      S_TOUCH_EV: begin
        if (kind_q != KIND_FREE) begin
          meta_we = 1'b1;
          meta_wd = {USERPAGE, runl_q, 1'b1};
          res_nxt.status = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_data_nxt.used_pages = used_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      hand_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      total_r     <= FRAMES_C;
      swap_r      <= 1'b0;
      cstart_r    <= '0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hand_r      <= hand_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOTAL:  total_r  <= cfg_wdata;
          CFG_SWAP:   swap_r   <= cfg_wdata[0];
          CFG_CSTART: cstart_r <= cfg_wdata[IDX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    run_r      <= run_nxt;
    steps_r    <= steps_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FRAMES_C) else $error("used count above frame count");
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> out_data.status == ST_OK)
    else $error("eviction reported with failing status");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> in_stall) else $error("request taken during clear");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import fa_clk_pkg::*;

  // Longest quiet stretch tolerated: covers a full-map allocate with an eviction
  // search of the clock hand, plus the reset clearing pass and stalls.
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  fa_in_t            in_data;
  logic              out_valid;
  logic              out_stall;
  fa_out_t           out_data;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CNT_W-1:0]  cfg_wdata;

  frame_allocator_clock_evict_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow frame map and registers.
  logic [1:0]            map_kind [FRAMES];
  logic [RUN_W-1:0]      map_run  [FRAMES];
  logic                  map_ref  [FRAMES];
  logic [OWNER_BITS-1:0] map_owner[FRAMES];
  int                    hand_pos;
  int                    used_frames;
  logic [10:0]           reg_total;
  logic                  reg_swap;
  logic [9:0]            reg_cstart;

  fa_in_t  req_q[$];      // request words waiting for the driver
  fa_out_t result_q[$];   // predicted result words, oldest first
  int      errors;
  int      idle_cycles;
  int      results_seen;
  logic    in_took;
  logic    quiet;          // no input gaps in this phase
  int      gap_left;
  int      out_gap_left;
  int      hold_left;
  logic    hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int managed_frames();
    return (reg_total > FRAMES) ? FRAMES : int'(reg_total);
  endfunction

  function automatic int hand_step(int h, int n);
    h++;
    if (h >= n) h = (int'(reg_cstart) < n) ? int'(reg_cstart) : 0;
    return h;
  endfunction

  // Applies one request to the shadow map and returns its result word.
  function automatic fa_out_t model_request(fa_in_t w);
    fa_out_t r;
    int n, run, s, h, e;
    n = managed_frames();
    r = '0;
    r.status = ST_BAD;
    case (w.opcode)
      OP_ALLOC: begin
        if (w.page_count != 0 && w.page_count <= MAX_RUN && w.page_kind != KIND_FREE) begin
          r.status = ST_NOMEM;
          run = 0;
          for (int i = 0; i < n; i++) begin
            run = (map_kind[i] == KIND_FREE) ? run + 1 : 0;
            if (run == w.page_count) begin
              s = i + 1 - run;
              for (int k = s; k <= i; k++) begin
                map_kind[k]  = w.page_kind;
                map_run[k]   = '0;
                map_owner[k] = w.owner_tag;
              end
              map_run[s] = w.page_count;
              used_frames += run;
              r.status = ST_OK;
              r.frame_out = s[9:0];
              break;
            end
          end
          // second chance: only single frames, only user frames
          if (r.status != ST_OK && reg_swap && w.page_count == 1 && n > 0) begin
            h = hand_step(hand_pos, n);
            for (int st = 0; st < 2 * n; st++) begin
              if (map_kind[h] == USERPAGE && !map_ref[h]) begin
                r.status       = ST_OK;
                r.frame_out    = h[9:0];
                r.evicted      = 1'b1;
                r.victim_owner = map_owner[h];
                map_kind[h]  = w.page_kind;
                map_owner[h] = w.owner_tag;
                map_ref[h]   = 1'b1;
                break;
              end
              map_ref[h] = 1'b0;
              if (st + 1 < 2 * n) h = hand_step(h, n);
            end
            hand_pos = h;
          end
        end
      end
      OP_FREE: begin
        if (w.frame_index < n && map_run[w.frame_index] != 0) begin
          e = w.frame_index + map_run[w.frame_index];
          if (e > FRAMES) e = FRAMES;
          for (int k = w.frame_index; k < e; k++) begin
            if (map_kind[k] != KIND_FREE && used_frames > 0) used_frames--;
            map_kind[k] = KIND_FREE;
            map_run[k]  = '0;
          end
          r.status = ST_OK;
        end
      end
      OP_TOUCH: begin
        if (w.frame_index < n && map_kind[w.frame_index] != KIND_FREE) begin
          map_kind[w.frame_index] = USERPAGE;
          map_ref[w.frame_index]  = 1'b1;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.used_pages = used_frames[10:0];
    return r;
  endfunction

  task automatic send_req(logic [1:0] op, int cnt, int kind, int owner, int fi);
    fa_in_t w;
    w.opcode      = op;
    w.page_count  = cnt[6:0];
    w.page_kind   = kind[1:0];
    w.owner_tag   = owner[15:0];
    w.frame_index = fi[9:0];
    result_q.push_back(model_request(w));
    req_q.push_back(w);
  endtask

  // Random request, biased toward well-formed allocs.
  task automatic send_random();
    int n, pick, cnt, kind, fi, r;
    n = managed_frames();
    pick = $urandom_range(99);
    cnt = ($urandom_range(9) < 7) ? $urandom_range(4, 1) :
          ($urandom_range(2) < 2) ? $urandom_range(MAX_RUN, 1) : $urandom_range(127);
    kind = ($urandom_range(9) != 0) ? $urandom_range(3, 1) : $urandom_range(3);
    fi = ($urandom_range(4) != 0) ? $urandom_range(n - 1) : $urandom_range(FRAMES - 1);
    if (pick < 22 && $urandom_range(9) < 7) begin
      // walk forward to the next recorded run start
      r = $urandom_range(n - 1);
      for (int k = 0; k < n; k++)
        if (map_run[(r + k) % n] != 0) begin
          fi = (r + k) % n;
          break;
        end
    end
    if (pick < 50)      send_req(OP_ALLOC, cnt, kind, $urandom, fi);
    else if (pick < 72) send_req(OP_FREE, cnt, kind, $urandom, fi);
    else if (pick < 96) send_req(OP_TOUCH, cnt, kind, $urandom, fi);
    else                send_req(OP_ILLEGAL, cnt, kind, $urandom, fi);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(int total, int swap, int cstart);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_TOTAL; cfg_wdata <= total[10:0];
    @(negedge clk);
    cfg_index <= CFG_SWAP; cfg_wdata <= swap[10:0];
    @(negedge clk);
    cfg_index <= CFG_CSTART; cfg_wdata <= cstart[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_total  = total[10:0];
    reg_swap   = swap[0];
    reg_cstart = cstart[9:0];
  endtask

  task automatic run_phase(int total, int swap, int cstart, int items);
    wait_drained();
    write_regs(total, swap, cstart);
    quiet = ($urandom_range(3) == 0);
    for (int i = 0; i < items; i++) send_random();
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Acceptance tracking, output checking and watchdog.
  always @(posedge clk) begin
    fa_out_t e;
    in_took <= in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (result_q.size() == 0) begin
        $display("%0t unexpected result word %h", $time, out_data);
        errors++;
      end else begin
        e = result_q.pop_front();
        check_field("status", e.status, out_data.status);
        check_field("frame_out", e.frame_out, out_data.frame_out);
        check_field("evicted", e.evicted, out_data.evicted);
        check_field("victim_owner", e.victim_owner, out_data.victim_owner);
        check_field("used_pages", e.used_pages, out_data.used_pages);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Request driver: new word only once the current one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_data  <= req_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= quiet ? 0 : gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold so the block backs up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen >= 150) begin
        out_stall <= 1'b1;
        hold_left <= hold_left + 1;
        if (hold_left >= HOLD_CYCLES) hold_done <= 1'b1;
      end else if (out_gap_left > 0) begin
        out_gap_left <= out_gap_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap_left <= gap_len();
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TOTAL;
    cfg_wdata = '0;
    errors = 0;
    idle_cycles = 0;
    results_seen = 0;
    in_took = 1'b0;
    quiet = 1'b0;
    gap_left = 0;
    out_gap_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    hand_pos = 0;
    used_frames = 0;
    reg_total = 11'd1024;
    reg_swap = 1'b0;
    reg_cstart = '0;
    for (int i = 0; i < FRAMES; i++) begin
      map_kind[i] = KIND_FREE;
      map_run[i] = '0;
      map_ref[i] = 1'b0;
      map_owner[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fill the whole map, then the corner cases.
    write_regs(1024, 0, 1023);
    for (int i = 0; i < 16; i++) send_req(OP_ALLOC, MAX_RUN, KERNELPAGE, 16'hFFFF - i, 0);
    send_req(OP_ALLOC, 1, USERPAGE, 0, 0);          // full map, no swap
    send_req(OP_ILLEGAL, 127, 3, 16'hFFFF, 1023);   // illegal opcode
    send_req(OP_ALLOC, 0, USERPAGE, 1, 0);          // zero length
    send_req(OP_ALLOC, MAX_RUN + 1, USERPAGE, 1, 0);
    send_req(OP_ALLOC, 1, KIND_FREE, 1, 0);         // kind zero
    send_req(OP_FREE, 1, 1, 0, 1);                  // not a run start
    send_req(OP_TOUCH, 1, 1, 0, 5);                 // kernel frame becomes user
    send_req(OP_FREE, 1, 1, 0, 0);
    send_req(OP_TOUCH, 1, 1, 0, 10);                // touch of a free frame
    send_req(OP_FREE, 1, 1, 0, 960);
    send_req(OP_ALLOC, 3, 3, 16'h0000, 0);
    quiet = 1'b1;
    for (int i = 0; i < 40; i++) send_random();

    run_phase(1024, 1, 1023, 30);
    // Small maps: eviction, wrap to clock_start, clock_start out of range.
    run_phase(64, 1, 5, 220);
    run_phase(16, 1, 20, 160);
    run_phase(1, 1, 0, 60);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fa_clk_pkg.sv
rtl/frame_allocator_clock_evict_top.sv
dv/testbench.sv
